// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL of the peak-to-peak level detector.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/wpp_pkg.sv =====
// Shared types, constants and the dB table builder for the level detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpp_pkg;

   localparam int SAMPLE_BITS   = 10;
   localparam int TIME_BITS     = 32;
   localparam int LEVEL_BITS    = 10;
   localparam int DB_BITS       = 10;
   localparam int EVENT_BITS    = 32;
   localparam int THR_BITS      = 10;
   localparam int MS_BITS       = 16;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 56;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(10);
   localparam logic [MS_BITS-1:0]  WINDOW_RESET    = MS_BITS'(50);
   localparam logic [MS_BITS-1:0]  HOLD_RESET      = MS_BITS'(300);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = '1;

   // dB table is split into banks addressed by the low level bits
   localparam int DB_BANK_BITS = 8;
   localparam int DB_SEL_BITS  = LEVEL_BITS - DB_BANK_BITS;
   localparam int DB_BANKS     = 2 ** DB_SEL_BITS;
   localparam int DB_BANK_SIZE = 2 ** DB_BANK_BITS;

   // log2 fraction bits and 320*log10(2) in Q24
   localparam int          LOG_FRAC          = 30;
   localparam logic [63:0] DB_PER_OCTAVE_Q24 = 64'd1616142483;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_WINDOW    = 2'd1,
      REG_HOLD      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THR_BITS-1:0] threshold;
      logic [MS_BITS-1:0]  window_len;
      logic [MS_BITS-1:0]  hold_len;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  loud;
      logic                  done;
      logic [EVENT_BITS-1:0] events;
      logic                  indicator;
   } result_type;

   typedef logic [DB_BITS-1:0] db_bank_type [DB_BANK_SIZE];

   // round(320*log10(x)) by bitwise log2; 0 for x of 0 or 1
   function automatic logic [DB_BITS-1:0] db_calc(logic [LEVEL_BITS-1:0] x);
      logic [63:0] m;
      logic [63:0] lg;
      logic [63:0] p;
      int          e;
      int          k;
      int          i;
      e = 0;
      if (x <= LEVEL_BITS'(1)) begin
         return '0;
      end
      for (k = 1; k < LEVEL_BITS; k++) begin
         if ((x >> k) != '0) begin
            e = k;
         end
      end
      m  = (64'(x) << LOG_FRAC) >> e;
      lg = 64'(e) << LOG_FRAC;
      for (i = LOG_FRAC - 1; i >= 0; i--) begin
         m = (m * m) >> LOG_FRAC;
         if (m >= (64'd2 << LOG_FRAC)) begin
            m  = m >> 1;
            lg = lg | (64'd1 << i);
         end
      end
      lg = lg >> 4;
      p  = lg * DB_PER_OCTAVE_Q24;
      return DB_BITS'((p + (64'd1 << 49)) >> 50);
   endfunction

   function automatic db_bank_type db_bank_build(logic [DB_SEL_BITS-1:0] bank);
      db_bank_type t;
      int          j;
      for (j = 0; j < DB_BANK_SIZE; j++) begin
         t[j] = db_calc({bank, DB_BANK_BITS'(j)});
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== sv/wpp_core.sv =====
// Window state of the level detector: running min/max, window close, level,
// loud edge counting and indicator hold timer. Uses wpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpp_core
   import wpp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   step,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [TIME_BITS-1:0]   time_ms,
   output result_type             result
);

   logic [SAMPLE_BITS-1:0] run_min_ff, run_min_in;
   logic [SAMPLE_BITS-1:0] run_max_ff, run_max_in;
   logic [TIME_BITS-1:0]   window_start_ff, window_start_in;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic                   loud_ff, loud_in;
   logic                   done_ff;
   logic [EVENT_BITS-1:0]  events_ff, events_in;
   logic                   hold_ff, hold_in;
   logic [TIME_BITS-1:0]   hold_start_ff, hold_start_in;

   logic [SAMPLE_BITS-1:0] min_cur;
   logic [SAMPLE_BITS-1:0] max_cur;
   logic [TIME_BITS-1:0]   elapsed;
   logic [TIME_BITS-1:0]   hold_elapsed;
   logic [LEVEL_BITS-1:0]  lvl;
   logic                   close;
   logic                   is_loud;
   logic                   rise;
   logic                   hold_clear;

   always_comb begin
      min_cur      = (sample < run_min_ff) ? sample : run_min_ff;
      max_cur      = (sample > run_max_ff) ? sample : run_max_ff;
      elapsed      = time_ms - window_start_ff;
      close        = elapsed >= TIME_BITS'(cfg.window_len);
      lvl          = (max_cur >= min_cur) ? LEVEL_BITS'(max_cur - min_cur) : '0;
      is_loud      = lvl >= cfg.threshold;
      rise         = close && is_loud && !loud_ff;
      hold_elapsed = time_ms - hold_start_ff;
      // a fresh hold has zero elapsed time, so only a zero length ends it at once
      hold_clear   = rise ? (cfg.hold_len == '0)
                          : (hold_elapsed >= TIME_BITS'(cfg.hold_len));
      hold_in      = (hold_ff || rise) && !hold_clear;
      hold_start_in = rise ? time_ms : hold_start_ff;
      events_in    = rise ? events_ff + EVENT_BITS'(1) : events_ff;

      if (close) begin
         run_min_in      = SAMPLE_MAX;
         run_max_in      = '0;
         window_start_in = time_ms;
         level_in        = lvl;
         loud_in         = is_loud;
      end else begin
         run_min_in      = min_cur;
         run_max_in      = max_cur;
         window_start_in = window_start_ff;
         level_in        = level_ff;
         loud_in         = loud_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff      <= SAMPLE_MAX;
         run_max_ff      <= '0;
         window_start_ff <= '0;
         level_ff        <= '0;
         loud_ff         <= 1'b0;
         done_ff         <= 1'b0;
         events_ff       <= '0;
         hold_ff         <= 1'b0;
         hold_start_ff   <= '0;
      end else if (step) begin
         run_min_ff      <= run_min_in;
         run_max_ff      <= run_max_in;
         window_start_ff <= window_start_in;
         level_ff        <= level_in;
         loud_ff         <= loud_in;
         done_ff         <= close;
         events_ff       <= events_in;
         hold_ff         <= hold_in;
         hold_start_ff   <= hold_start_in;
      end
   end

   assign result.level     = level_ff;
   assign result.loud      = loud_ff;
   assign result.done      = done_ff;
   assign result.events    = events_ff;
   assign result.indicator = hold_ff;

endmodule

`default_nettype wire

// ===== sv/wpp_db.sv =====
// Level to 1/16 dB lookup: banked constant table read, then bank select.
// Two register stages, both moved by advance. Uses wpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpp_db
   import wpp_pkg::*;
(
   input  logic                  clock,
   input  logic                  advance,
   input  logic [LEVEL_BITS-1:0] level,
   output logic [DB_BITS-1:0]    db
);

   logic [DB_BITS-1:0]     bank_ff [DB_BANKS];
   logic [DB_SEL_BITS-1:0] sel_ff;
   logic [DB_BITS-1:0]     db_ff;

   for (genvar b = 0; b < DB_BANKS; b++) begin : g_bank
      localparam db_bank_type ROM = db_bank_build(DB_SEL_BITS'(b));
      always_ff @(posedge clock) begin
         if (advance) begin
            bank_ff[b] <= ROM[level[DB_BANK_BITS-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sel_ff <= level[LEVEL_BITS-1 -: DB_SEL_BITS];
         db_ff  <= bank_ff[sel_ff];
      end
   end

   assign db = db_ff;

endmodule

`default_nettype wire

// ===== sv/windowed_peak_to_peak_level_detector.sv =====
// Windowed peak-to-peak level detector, top level.
// Needs wpp_pkg, wpp_core, wpp_db and assert_macros.svh.
//
// Use: each request on req_ carries one ADC sample and its millisecond
// timestamp; each request gives exactly one result on rsp_, in order. A
// result carries the level of the last closed window, its value in 1/16 dB,
// the loud flag, the rising-edge event count and the hold-timed indicator;
// rsp_tuser is high when that request closed a window.
// Throughput is one request per cycle unless the response side stalls. The
// accepting edge loads the input register; a request then passes window state
// update, dB bank read and dB bank select before rsp_tvalid, the last two set
// by the banked dB table.
// When rsp_tready is low while a result waits, the whole pipeline holds;
// req_tready comes from a one-entry skid register, so one more request is
// taken during a stall and req_tready drops the cycle after.
// Reset (synchronous, active high) empties the pipeline, restores the window
// state and loads the register defaults: threshold 10, window 50 ms, hold
// 300 ms. Registers sit on the csr_ port at byte addresses 0, 4 and 8; the
// user must write them only while no request is in flight. The block does not check it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module windowed_peak_to_peak_level_detector
   import wpp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // sample [9:0], time_ms [41:10], zero pad [47:42]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // level [9:0], level_db_q4 [19:10], loud [20], events [52:21],
   // indicator [53], zero pad [55:54]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // window_done [0]
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // configuration registers
   cfg_type       cfg_ff;
   logic          csr_write;
   csr_index_type csr_index;

   // handshake and pipeline
   logic                   adv;
   logic                   req_acc;
   logic                   skid_vld_ff;
   logic [SAMPLE_BITS-1:0] skid_sample_ff;
   logic [TIME_BITS-1:0]   skid_time_ff;
   logic                   s1_vld_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [TIME_BITS-1:0]   s1_time_ff;
   logic                   s2_vld_ff;
   logic                   s3_vld_ff;
   logic                   out_vld_ff;
   result_type             core_res;
   result_type             s3_res_ff;
   result_type             out_res_ff;
   logic [DB_BITS-1:0]     out_db;

   logic [SAMPLE_BITS-1:0] req_sample;
   logic [TIME_BITS-1:0]   req_time;

   assign req_sample = req_tdata[SAMPLE_BITS-1:0];
   assign req_time   = req_tdata[SAMPLE_BITS +: TIME_BITS];

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= THRESHOLD_RESET;
         cfg_ff.window_len <= WINDOW_RESET;
         cfg_ff.hold_len   <= HOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_THRESHOLD: cfg_ff.threshold  <= csr_pwdata[THR_BITS-1:0];
            REG_WINDOW:    cfg_ff.window_len <= csr_pwdata[MS_BITS-1:0];
            REG_HOLD:      cfg_ff.hold_len   <= csr_pwdata[MS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_THRESHOLD: csr_prdata = CSR_DATA_BITS'(cfg_ff.threshold);
         REG_WINDOW:    csr_prdata = CSR_DATA_BITS'(cfg_ff.window_len);
         REG_HOLD:      csr_prdata = CSR_DATA_BITS'(cfg_ff.hold_len);
         default:       csr_prdata = '0;
      endcase
   end

   // ---- request side ----
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = !skid_vld_ff;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (adv) begin
         skid_vld_ff <= 1'b0;
         s1_vld_ff   <= skid_vld_ff || req_acc;
         s2_vld_ff   <= s1_vld_ff;
         s3_vld_ff   <= s2_vld_ff;
         out_vld_ff  <= s3_vld_ff;
      end else if (req_acc) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sample_ff <= skid_vld_ff ? skid_sample_ff : req_sample;
         s1_time_ff   <= skid_vld_ff ? skid_time_ff : req_time;
         s3_res_ff    <= core_res;
         out_res_ff   <= s3_res_ff;
      end else if (req_acc) begin
         skid_sample_ff <= req_sample;
         skid_time_ff   <= req_time;
      end
   end

   wpp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step    (adv && s1_vld_ff),
      .sample  (s1_sample_ff),
      .time_ms (s1_time_ff),
      .result  (core_res)
   );

   // db lags the core result by two stages, in step with s3 and out
   wpp_db u_db (
      .clock   (clock),
      .advance (adv),
      .level   (core_res.level),
      .db      (out_db)
   );

   // ---- response side ----
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_res_ff.indicator, out_res_ff.events,
                        out_res_ff.loud, out_db, out_res_ff.level};
   assign rsp_tuser  = out_res_ff.done;

   // ---- checks ----
   `ASSERT_CLK(a_skid_only_in_stall, clock, reset,
      skid_vld_ff |-> out_vld_ff,
      "skid full without a stalled result")
   `ASSERT_CLK(a_event_step, clock, reset,
      (core_res.events != $past(core_res.events)) |->
         (core_res.done && (core_res.events == $past(core_res.events) + 32'd1)),
      "event count moved outside a window close")
   `ASSERT_CLK(a_indicator_rise, clock, reset,
      (core_res.indicator && !$past(core_res.indicator)) |-> core_res.done,
      "indicator set without a window close")
   `ASSERT_CLK(a_db_zero_level, clock, reset,
      (out_vld_ff && (out_res_ff.level == '0)) |-> (out_db == '0),
      "dB value out of step with level")

endmodule

`default_nettype wire

// ===== tb/peak_level_checker.sv =====
// Checker for the windowed peak-to-peak level detector: follows the register
// port, predicts each result from accepted requests and compares, in order.
// Depends on wpp_pkg.
`timescale 1ns / 1ps

module peak_level_checker
   import wpp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending
);

   localparam int          FRAC_BITS     = 30;
   localparam logic [63:0] OCTAVE_DB_Q24 = 64'd1616142483;   // 320*log10(2)

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic [DB_BITS-1:0]    level_db_q4;
      logic                  loud;
      logic                  window_done;
      logic [EVENT_BITS-1:0] event_count;
      logic                  indicator;
   } level_report_type;

   level_report_type due_reports[$];

   logic [THR_BITS-1:0]    thr_cfg;
   logic [MS_BITS-1:0]     win_cfg;
   logic [MS_BITS-1:0]     hold_cfg;
   logic [SAMPLE_BITS-1:0] lo_seen;
   logic [SAMPLE_BITS-1:0] hi_seen;
   logic [TIME_BITS-1:0]   win_t0;
   logic [LEVEL_BITS-1:0]  lvl_q;
   logic [DB_BITS-1:0]     db_q;
   logic                   loud_q;
   logic [EVENT_BITS-1:0]  event_cnt;
   logic                   hold_on;
   logic [TIME_BITS-1:0]   hold_t0;
   int                     mismatches = 0;

   // 16*20*log10(lvl), rounded; log2 by repeated squaring of the mantissa
   function automatic logic [DB_BITS-1:0] db_q4_of(input logic [LEVEL_BITS-1:0] lvl);
      logic [63:0] mant;
      logic [63:0] acc;
      logic [63:0] prod;
      int          msb;
      int          b;
      if (lvl < LEVEL_BITS'(2)) begin
         return '0;
      end
      msb = 0;
      for (b = 0; b < LEVEL_BITS; b++) begin
         if (lvl[b]) begin
            msb = b;
         end
      end
      mant = 64'(lvl) << (FRAC_BITS - msb);
      acc  = 64'(msb) << FRAC_BITS;
      for (b = FRAC_BITS - 1; b >= 0; b--) begin
         mant = (mant * mant) >> FRAC_BITS;
         if (mant[FRAC_BITS+1]) begin
            mant   = mant >> 1;
            acc[b] = 1'b1;
         end
      end
      prod = (acc >> 4) * OCTAVE_DB_Q24;
      return DB_BITS'((prod + (64'd1 << 49)) >> 50);
   endfunction

   function automatic level_report_type fold_sample(input logic [SAMPLE_BITS-1:0] s,
                                                    input logic [TIME_BITS-1:0] now);
      level_report_type      r;
      logic [LEVEL_BITS-1:0] lvl;
      logic                  now_loud;
      r.window_done = 1'b0;
      if (s < lo_seen) lo_seen = s;
      if (s > hi_seen) hi_seen = s;
      if (TIME_BITS'(now - win_t0) >= TIME_BITS'(win_cfg)) begin
         lvl      = (hi_seen >= lo_seen) ? LEVEL_BITS'(hi_seen - lo_seen) : '0;
         lvl_q    = lvl;
         db_q     = db_q4_of(lvl);
         now_loud = (lvl >= thr_cfg);
         // only a quiet-to-loud step counts and restarts the hold timer
         if (now_loud && !loud_q) begin
            event_cnt = event_cnt + 1'b1;
            hold_on   = 1'b1;
            hold_t0   = now;
         end
         loud_q        = now_loud;
         lo_seen       = SAMPLE_MAX;
         hi_seen       = '0;
         win_t0        = now;
         r.window_done = 1'b1;
      end
      if (hold_on && TIME_BITS'(now - hold_t0) >= TIME_BITS'(hold_cfg)) begin
         hold_on = 1'b0;
      end
      r.level       = lvl_q;
      r.level_db_q4 = db_q;
      r.loud        = loud_q;
      r.event_count = event_cnt;
      r.indicator   = hold_on;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      level_report_type want;
      level_report_type got;
      if (reset) begin
         thr_cfg   = THRESHOLD_RESET;
         win_cfg   = WINDOW_RESET;
         hold_cfg  = HOLD_RESET;
         lo_seen   = SAMPLE_MAX;
         hi_seen   = '0;
         win_t0    = '0;
         lvl_q     = '0;
         db_q      = '0;
         loud_q    = 1'b0;
         event_cnt = '0;
         hold_on   = 1'b0;
         hold_t0   = '0;
         due_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               REG_THRESHOLD: thr_cfg  = csr_pwdata[THR_BITS-1:0];
               REG_WINDOW:    win_cfg  = csr_pwdata[MS_BITS-1:0];
               REG_HOLD:      hold_cfg = csr_pwdata[MS_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.level       = rsp_tdata[9:0];
            got.level_db_q4 = rsp_tdata[19:10];
            got.loud        = rsp_tdata[20];
            got.event_count = rsp_tdata[52:21];
            got.indicator   = rsp_tdata[53];
            got.window_done = rsp_tuser;
            if (due_reports.size() == 0) begin
               $error("result with no request outstanding");
               mismatches++;
            end else begin
               want = due_reports.pop_front();
               check_field("level", 32'(want.level), 32'(got.level));
               check_field("level_db_q4", 32'(want.level_db_q4), 32'(got.level_db_q4));
               check_field("loud", 32'(want.loud), 32'(got.loud));
               check_field("window_done", 32'(want.window_done), 32'(got.window_done));
               check_field("events", want.event_count, got.event_count);
               check_field("indicator", 32'(want.indicator), 32'(got.indicator));
            end
         end
         if (req_tvalid && req_tready) begin
            due_reports.push_back(fold_sample(req_tdata[9:0], req_tdata[41:10]));
         end
      end
      fail_count <= mismatches;
      pending    <= due_reports.size();
   end

endmodule

// ===== tb/windowed_peak_to_peak_level_detector_tb.sv =====
// Top of the level detector testbench: clock, reset, request and register
// stimulus, response back-pressure, watchdog and verdict.
// Depends on wpp_pkg, the detector RTL and peak_level_checker.
`timescale 1ns / 1ps

module windowed_peak_to_peak_level_detector_tb;
   import wpp_pkg::*;

   localparam int STALL_LIMIT = 2000;
   // beyond the last register, writes here must change nothing
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_ADDR = 4'd12;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int fail_count;
   int pending;
   int quiet_cycles  = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   windowed_peak_to_peak_level_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   peak_level_checker level_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic [SAMPLE_BITS-1:0] s, input logic [TIME_BITS-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, t, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off new requests until every outstanding result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // leaves psel high so back-to-back writes skip the idle phase;
   // penable is low on entry
   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [THR_BITS-1:0] thr, input logic [MS_BITS-1:0] win,
                             input logic [MS_BITS-1:0] hold);
      drain();
      repeat (6) @(negedge clock);
      // upper bits random: only the low field bits may take effect
      csr_write({REG_THRESHOLD, 2'b00}, {22'($urandom_range(0, 4194303)), thr});
      csr_write({REG_WINDOW, 2'b00}, {16'($urandom), win});
      csr_write({REG_HOLD, 2'b00}, {16'($urandom), hold});
      csr_write(CSR_SPARE_ADDR, $urandom);
      csr_psel   <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(input int n, input logic [THR_BITS-1:0] thr,
                             input logic [MS_BITS-1:0] win, input logic [MS_BITS-1:0] hold,
                             input int sidle, input int sstall);
      int                   i;
      int                   v;
      int                   pick;
      int                   base;
      int                   amp;
      logic [TIME_BITS-1:0] now;
      set_config(thr, win, hold);
      send_idle_pct = sidle;
      rsp_stall_pct = sstall;
      now  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400) : $urandom;
      base = $urandom_range(0, 1023);
      amp  = $urandom_range(0, 1023);
      for (i = 0; i < n; i++) begin
         // bursts of quiet and loud signal around a moving base
         if ($urandom_range(7) == 0) begin
            base = $urandom_range(0, 1023);
            amp  = $urandom_range(1) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
         end
         v = base + $urandom_range(0, amp);
         if (v > 1023) v = 1023;
         if ($urandom_range(9) == 0) v = $urandom_range(0, 1023);
         pick = $urandom_range(99);
         if (pick < 70) begin
            now = now + $urandom_range(0, 3);
         end else if (pick < 90) begin
            now = now + $urandom_range(0, 2 * int'(win) + 1);
         end else if (pick < 96) begin
            now = now + $urandom_range(0, 70000);
         end else begin
            now = $urandom;
         end
         send_item(SAMPLE_BITS'(v), now);
         if (i == n / 2 || $urandom_range(63) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: threshold 10, 50 ms window, 300 ms hold
      send_item(10'd0, 32'd0);
      send_item(10'd1023, 32'd10);
      send_item(10'd512, 32'd50);
      send_item(10'd5, 32'd60);
      send_item(10'd5, 32'd110);              // two equal samples in the window, level 0
      send_item(10'd6, 32'd120);
      send_item(10'd7, 32'd160);              // level 1 gives 0 dB
      send_item(10'd0, 32'd170);
      send_item(10'd1023, 32'd220);
      send_item(10'd100, 32'd520);            // hold runs out exactly
      send_item(10'd0, 32'hFFFF_FFF0);
      send_item(10'd1023, 32'h0000_0022);     // elapsed time across the wrap
      send_item(10'd100, 32'h0000_0030);
      send_item(10'd110, 32'h0000_0054);      // level equal to threshold
      send_item(10'd100, 32'h0000_0060);
      send_item(10'd109, 32'h0000_0086);      // one below threshold

      // zero window and zero hold
      set_config(10'd0, 16'd0, 16'd0);
      send_item(10'd1023, 32'd1);
      send_item(10'd0, 32'd1);
      send_item(10'd512, 32'd2);
      send_item(10'd3, 32'd2);

      set_config(10'd1023, 16'd65535, 16'd65535);
      send_item(10'd0, 32'd5);
      send_item(10'd1023, 32'd70000);
      send_item(10'd1023, 32'd135534);

      run_random(70, 10'd10, 16'd8, 16'd40, 0, 0);
      run_random(60, 10'd0, 16'd1, 16'd0, 59, 0);
      run_random(60, 10'd1023, 16'd3, 16'd65535, 0, 59);
      run_random(50, 10'd300, 16'd65535, 16'd20, 11, 11);
      run_random(50, 10'($urandom), 16'd0, 16'd5, 0, 0);
      run_random(60, 10'd40, 16'd20, 16'd100, 59, 0);
      run_random(50, 10'($urandom), 16'($urandom_range(1, 30)),
                 16'($urandom_range(0, 200)), 0, 59);
      run_random(50, 10'd200, 16'd12, 16'd30, 11, 11);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/wpp_pkg.sv
sv/wpp_core.sv
sv/wpp_db.sv
sv/windowed_peak_to_peak_level_detector.sv
tb/peak_level_checker.sv
tb/windowed_peak_to_peak_level_detector_tb.sv
